// ----- design/tgfe_pkg.sv -----
// shared types and constants for the text glyph framebuffer engine
// used by the top, tgfe_front and tgfe_back; no dependencies
package tgfe_pkg;

  // function codes of an input request
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_DRAW    = 2'd1;
  localparam logic [1:0] FUNC_REFRESH = 2'd2;

  // status codes of a result
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_SYMBOL = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR   = 2'd2;

  // first character code held in the font
  localparam logic [7:0] FIRST_CODE = 8'd32;

  // lcd command bytes sent ahead of each page
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_PAGE   = 8'hB0;

  // command bytes per page and index of the last page
  localparam int         REF_HEADER = 3;
  localparam logic [1:0] PAGE_LAST  = 2'd3;

  // classified request kinds
  typedef enum logic [1:0] {
    K_NOP     = 2'd0,
    K_LOAD    = 2'd1,
    K_DRAW    = 2'd2,
    K_REFRESH = 2'd3
  } kind_t;

  // one queued request, as handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  status;
    logic [11:0] font_address;
    logic [7:0]  font_byte;
    logic        text_line;
    logic [7:0]  glyph;
  } cmd_t;

endpackage

// ----- design/text_glyph_framebuffer_engine.sv -----
// text glyph framebuffer engine top: front end, command queue and back end
// a nop goes from idle straight to the result state; a load passes S_LOAD, a refresh
// byte S_REF and a draw S_MUL, S_WIDTH and the S_RUN column loop through the font
// banks; the back end takes the next request only after each result; results cannot be
// stalled; after reset busy stays high while the frame store is cleared
module text_glyph_framebuffer_engine import tgfe_pkg::*; #(
  parameter int COLUMNS       = 128,
  parameter int FONT_GLYPHS   = 96,
  parameter int GLYPH_COLUMNS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_font_address,
  input  logic [7:0]  in_font_byte,
  input  logic        in_text_line,
  input  logic [7:0]  in_symbol,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_frame_end,
  output logic [1:0]  out_status
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  logic clearing;

  // request classification and queue
  tgfe_front #(
    .FONT_GLYPHS   (FONT_GLYPHS),
    .GLYPH_COLUMNS (GLYPH_COLUMNS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .clearing        (clearing),
    .in_func         (in_func),
    .in_font_address (in_font_address),
    .in_font_byte    (in_font_byte),
    .in_text_line    (in_text_line),
    .in_symbol       (in_symbol),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop)
  );

  // execution and stores
  tgfe_back #(
    .COLUMNS       (COLUMNS),
    .FONT_GLYPHS   (FONT_GLYPHS),
    .GLYPH_COLUMNS (GLYPH_COLUMNS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_is_data   (out_is_data),
    .out_frame_end (out_frame_end),
    .out_status    (out_status)
  );

endmodule

// ----- design/tgfe_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
module tgfe_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/tgfe_front.sv -----
// front end: accepts requests, checks ranges, queues classified commands
// depends on tgfe_pkg
module tgfe_front import tgfe_pkg::*; #(
  parameter int FONT_GLYPHS   = 96,
  parameter int GLYPH_COLUMNS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        clearing,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_font_address,
  input  logic [7:0]  in_font_byte,
  input  logic        in_text_line,
  input  logic [7:0]  in_symbol,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  localparam int REC_BYTES  = 1 + 2 * GLYPH_COLUMNS;
  localparam int FONT_BYTES = FONT_GLYPHS * REC_BYTES;
  localparam int FB_W       = $clog2(FONT_BYTES + 1);
  localparam int CMP_W      = (FB_W > 12) ? FB_W : 12;
  localparam int Q_DEPTH    = 2;

  cmd_t       cls;
  logic       push;
  cmd_t       entry_r [Q_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  // classify the incoming request
  always_comb begin
    cls              = '0;
    cls.font_address = in_font_address;
    cls.font_byte    = in_font_byte;
    cls.text_line    = in_text_line;
    cls.glyph        = in_symbol - FIRST_CODE;
    cls.kind         = K_NOP;
    cls.status       = ST_OK;
    unique case (in_func)
      FUNC_LOAD: begin
        if (CMP_W'(in_font_address) < CMP_W'(FONT_BYTES)) begin
          cls.kind = K_LOAD;
        end else begin
          cls.status = ST_BAD_ADDR;
        end
      end
      FUNC_DRAW: begin
        if ((in_symbol >= FIRST_CODE) &&
            ({1'b0, cls.glyph} < 9'(FONT_GLYPHS))) begin
          cls.kind = K_DRAW;
        end else begin
          cls.status = ST_BAD_SYMBOL;
        end
      end
      FUNC_REFRESH: begin
        cls.kind = K_REFRESH;
      end
      default: begin
        cls.kind = K_NOP;
      end
    endcase
  end

  // two-entry command queue
  assign busy    = (count_r == 2'(Q_DEPTH)) || clearing;
  assign push    = start && !busy;
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'(Q_DEPTH)) |-> !push)
    else $error("request taken into a full queue");
`endif

endmodule

// ----- design/tgfe_back.sv -----
// back end: clearing pass, font loads, glyph drawing and refresh streaming
// depends on tgfe_pkg and tgfe_ram
module tgfe_back import tgfe_pkg::*; #(
  parameter int COLUMNS       = 128,
  parameter int FONT_GLYPHS   = 96,
  parameter int GLYPH_COLUMNS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       clearing,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_frame_end,
  output logic [1:0] out_status
);

  localparam int REC_BYTES  = 1 + 2 * GLYPH_COLUMNS;
  localparam int FONT_BYTES = FONT_GLYPHS * REC_BYTES;
  localparam int FA_W       = $clog2(FONT_BYTES + 1);
  localparam int BANK_DEPTH = (FONT_BYTES + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int FR_DEPTH   = 2 * COLUMNS;
  localparam int FR_AW      = $clog2(FR_DEPTH);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int SUM_W      = 9;
  localparam int GI_W       = $clog2(GLYPH_COLUMNS + 1);
  localparam int K_W        = $clog2(COLUMNS + REF_HEADER);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_LOAD   = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_WIDTH  = 8'b0001_0000,
    S_RUN    = 8'b0010_0000,
    S_REF    = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [FA_W-1:0]    base_r, base_nxt;
  logic [FA_W-1:0]    ptr_r, ptr_nxt;
  logic [GI_W-1:0]    rd_i_r, rd_i_nxt;
  logic               wr_valid_r, wr_valid_nxt;
  logic [SUM_W-1:0]   wr_col_r, wr_col_nxt;
  logic               first_r, first_nxt;
  logic [7:0]         width_r, width_nxt;
  logic [COL_W-1:0]   cur_up_r, cur_up_nxt;
  logic [COL_W-1:0]   cur_lo_r, cur_lo_nxt;
  logic [1:0]         page_r, page_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic [FR_AW-1:0]   clr_r, clr_nxt;
  logic [7:0]         res_byte_r, res_byte_nxt;
  logic               res_data_r, res_data_nxt;
  logic               res_fend_r, res_fend_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               res_ram_r, res_ram_nxt;
  logic               res_sel_r, res_sel_nxt;
  logic               font_par_r;

  logic [FA_W-1:0]    rd_a;
  logic [FA_W:0]      rd_a_inc;
  logic [BANK_AW-1:0] fb0_raddr, fb1_raddr, fb_waddr;
  logic               fb0_we, fb1_we;
  logic [7:0]         fb0_rdata, fb1_rdata;
  logic [7:0]         byte_a, byte_a1;
  logic               fr_we;
  logic [FR_AW-1:0]   fr_waddr, fr_raddr;
  logic [7:0]         fr_wdata_up, fr_wdata_lo;
  logic [7:0]         fr_rdata_up, fr_rdata_lo;
  logic [COL_W-1:0]   cur_sel, cur_new;
  logic [SUM_W-1:0]   cur_sum;
  logic [FR_AW-1:0]   line_off, page_off;

  // font store split into even and odd byte banks for two reads a cycle
  assign rd_a_inc  = {1'b0, rd_a} + 1'b1;
  assign fb0_raddr = BANK_AW'(rd_a_inc >> 1);
  assign fb1_raddr = BANK_AW'(rd_a >> 1);
  assign fb_waddr  = BANK_AW'(cmd_r.font_address >> 1);
  assign byte_a    = font_par_r ? fb1_rdata : fb0_rdata;
  assign byte_a1   = font_par_r ? fb0_rdata : fb1_rdata;

  tgfe_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_font_even (
    .clk   (clk),
    .we    (fb0_we),
    .waddr (fb_waddr),
    .wdata (cmd_r.font_byte),
    .raddr (fb0_raddr),
    .rdata (fb0_rdata)
  );

  tgfe_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_font_odd (
    .clk   (clk),
    .we    (fb1_we),
    .waddr (fb_waddr),
    .wdata (cmd_r.font_byte),
    .raddr (fb1_raddr),
    .rdata (fb1_rdata)
  );

  // frame store: upper pages (0, 2) and lower pages (1, 3) of each text line
  tgfe_ram #(.WIDTH(8), .DEPTH(FR_DEPTH)) u_frame_up (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata_up),
    .raddr (fr_raddr),
    .rdata (fr_rdata_up)
  );

  tgfe_ram #(.WIDTH(8), .DEPTH(FR_DEPTH)) u_frame_lo (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata_lo),
    .raddr (fr_raddr),
    .rdata (fr_rdata_lo)
  );

  // cursor of the selected line and its saturated advance
  assign cur_sel  = cmd_r.text_line ? cur_lo_r : cur_up_r;
  assign cur_sum  = SUM_W'(cur_sel) + SUM_W'(width_r);
  assign cur_new  = (cur_sum > SUM_W'(COLUMNS)) ? COL_W'(COLUMNS) : COL_W'(cur_sum);
  assign line_off = cmd_r.text_line ? FR_AW'(COLUMNS) : '0;

  // refresh read address: page pair offset plus data column
  assign page_off = page_r[1] ? FR_AW'(COLUMNS) : '0;
  assign fr_raddr = page_off + FR_AW'(k_r - K_W'(REF_HEADER));

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    base_nxt       = base_r;
    ptr_nxt        = ptr_r;
    rd_i_nxt       = rd_i_r;
    wr_valid_nxt   = 1'b0;
    wr_col_nxt     = wr_col_r;
    first_nxt      = 1'b0;
    width_nxt      = width_r;
    cur_up_nxt     = cur_up_r;
    cur_lo_nxt     = cur_lo_r;
    page_nxt       = page_r;
    k_nxt          = k_r;
    clr_nxt        = clr_r;
    res_byte_nxt   = res_byte_r;
    res_data_nxt   = res_data_r;
    res_fend_nxt   = res_fend_r;
    res_status_nxt = res_status_r;
    res_ram_nxt    = res_ram_r;
    res_sel_nxt    = res_sel_r;
    q_pop          = 1'b0;
    rd_a           = base_r;
    fb0_we         = 1'b0;
    fb1_we         = 1'b0;
    fr_we          = 1'b0;
    fr_waddr       = line_off + FR_AW'(wr_col_r);
    fr_wdata_up    = byte_a;
    fr_wdata_lo    = byte_a1;
    unique case (state_r)
      S_CLEAR: begin
        fr_we       = 1'b1;
        fr_waddr    = clr_r;
        fr_wdata_up = '0;
        fr_wdata_lo = '0;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == FR_AW'(FR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          res_byte_nxt   = '0;
          res_data_nxt   = 1'b0;
          res_fend_nxt   = 1'b0;
          res_status_nxt = q_cmd.status;
          res_ram_nxt    = 1'b0;
          unique case (q_cmd.kind)
            K_LOAD:    state_nxt = S_LOAD;
            K_DRAW:    state_nxt = S_MUL;
            K_REFRESH: state_nxt = S_REF;
            default:   state_nxt = S_RESULT;
          endcase
        end
      end
      S_LOAD: begin
        fb0_we    = !cmd_r.font_address[0];
        fb1_we    = cmd_r.font_address[0];
        state_nxt = S_RESULT;
      end
      S_MUL: begin
        base_nxt  = FA_W'(32'(cmd_r.glyph) * REC_BYTES);
        state_nxt = S_WIDTH;
      end
      S_WIDTH: begin
        // read the width byte, then the first column pair
        rd_a      = base_r;
        ptr_nxt   = base_r + 1'b1;
        rd_i_nxt  = '0;
        first_nxt = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        rd_a = ptr_r;
        if (first_r) begin
          width_nxt = byte_a;
        end
        // write the pair read last cycle, dropping columns past the row
        if (wr_valid_r && (wr_col_r < SUM_W'(COLUMNS))) begin
          fr_we = 1'b1;
        end
        if (rd_i_r < GI_W'(GLYPH_COLUMNS)) begin
          ptr_nxt      = ptr_r + FA_W'(2);
          rd_i_nxt     = rd_i_r + 1'b1;
          wr_valid_nxt = 1'b1;
          wr_col_nxt   = SUM_W'(cur_sel) + SUM_W'(rd_i_r);
        end else if (!wr_valid_r) begin
          if (cmd_r.text_line) begin
            cur_lo_nxt = cur_new;
          end else begin
            cur_up_nxt = cur_new;
          end
          state_nxt = S_RESULT;
        end
      end
      S_REF: begin
        priority if (k_r == K_W'(0)) begin
          res_byte_nxt = CMD_COL_LO;
        end else if (k_r == K_W'(1)) begin
          res_byte_nxt = CMD_COL_HI;
        end else if (k_r == K_W'(2)) begin
          res_byte_nxt = CMD_PAGE + {6'b0, page_r};
        end else begin
          res_data_nxt = 1'b1;
          res_ram_nxt  = 1'b1;
          res_sel_nxt  = page_r[0];
        end
        // advance stream position, wrapping after the last page
        if (k_r == K_W'(COLUMNS + REF_HEADER - 1)) begin
          k_nxt = '0;
          if (page_r == PAGE_LAST) begin
            page_nxt     = '0;
            res_fend_nxt = 1'b1;
          end else begin
            page_nxt = page_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      cur_up_r   <= '0;
      cur_lo_r   <= '0;
      page_r     <= '0;
      k_r        <= '0;
      wr_valid_r <= 1'b0;
      first_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      cur_up_r   <= cur_up_nxt;
      cur_lo_r   <= cur_lo_nxt;
      page_r     <= page_nxt;
      k_r        <= k_nxt;
      wr_valid_r <= wr_valid_nxt;
      first_r    <= first_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    base_r       <= base_nxt;
    ptr_r        <= ptr_nxt;
    rd_i_r       <= rd_i_nxt;
    wr_col_r     <= wr_col_nxt;
    width_r      <= width_nxt;
    res_byte_r   <= res_byte_nxt;
    res_data_r   <= res_data_nxt;
    res_fend_r   <= res_fend_nxt;
    res_status_r <= res_status_nxt;
    res_ram_r    <= res_ram_nxt;
    res_sel_r    <= res_sel_nxt;
    font_par_r   <= rd_a[0];
  end

  // result port
  assign clearing      = (state_r == S_CLEAR);
  assign out_valid     = (state_r == S_RESULT);
  assign out_byte      = res_ram_r ? (res_sel_r ? fr_rdata_lo : fr_rdata_up) : res_byte_r;
  assign out_is_data   = res_data_r;
  assign out_frame_end = res_fend_r;
  assign out_status    = res_status_r;

`ifndef SYNTH
  a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && (state_r == S_IDLE)))
    else $error("command taken outside idle or from an empty queue");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_up_r <= COL_W'(COLUMNS)) && (cur_lo_r <= COL_W'(COLUMNS)))
    else $error("cursor past the row end");

  a_stream_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= K_W'(COLUMNS + REF_HEADER - 1))
    else $error("refresh position past the page");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");
`endif

endmodule
